FILE: sv/jetp_pkg.sv
// Shared types and constants of the Julia-set escape-time pixel engine.
// Holds the payload structs, the register map and the fixed-point widths.
// Used by every module of the block; depends on nothing.
package jetp_pkg;

	localparam int COLUMN_BITS    = 8;
	localparam int ROW_BITS       = 7;
	localparam int FRACTION_BITS  = 12;
	localparam int MAX_ITERATIONS = 4;
	localparam int PALETTE_LENGTH = 140;

	localparam int VALUE_W = 16;
	localparam int PITCH_W = 15;
	localparam int COUNT_W = 3;
	localparam int SLOT_W  = 8;
	localparam int INDEX_W = 3;

	// A start point is at most 16 + 14 + 23 bits of magnitude summed, which fits 25 bits signed.
	localparam int Z_W    = 25;
	localparam int PROD_W = 2 * Z_W;

	localparam logic signed [VALUE_W-1:0] VIEW_LEFT_RESET      = -16'sd2048;
	localparam logic signed [VALUE_W-1:0] VIEW_TOP_RESET       = -16'sd2048;
	localparam logic        [PITCH_W-1:0] PITCH_X_RESET        = 15'd51;
	localparam logic        [PITCH_W-1:0] PITCH_Y_RESET        = 15'd197;
	localparam logic signed [VALUE_W-1:0] ANIM_LOW_RESET       = 16'sd1638;
	localparam logic signed [VALUE_W-1:0] ANIM_HIGH_RESET      = 16'sd4096;
	localparam logic        [PITCH_W-1:0] ANIM_INCREMENT_RESET = 15'd41;
	localparam logic signed [VALUE_W-1:0] ANIM_VALUE_RESET     = 16'sd1638;

	typedef enum logic [INDEX_W-1:0] {
		REG_VIEW_LEFT      = 3'd0,
		REG_VIEW_TOP       = 3'd1,
		REG_PITCH_X        = 3'd2,
		REG_PITCH_Y        = 3'd3,
		REG_ANIM_LOW       = 3'd4,
		REG_ANIM_HIGH      = 3'd5,
		REG_ANIM_INCREMENT = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic [COLUMN_BITS-1:0] column;
		logic [ROW_BITS-1:0]    row;
		logic                   end_of_frame;
	} pixel_req_t;

	typedef struct packed {
		logic [COLUMN_BITS-1:0] pixel_column;
		logic [ROW_BITS-1:0]    pixel_row;
		logic [COUNT_W-1:0]     escape_count;
		logic [SLOT_W-1:0]      colour_slot;
	} pixel_res_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] view_left;
		logic signed [VALUE_W-1:0] view_top;
		logic        [PITCH_W-1:0] pitch_x;
		logic        [PITCH_W-1:0] pitch_y;
	} view_cfg_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] anim_low;
		logic signed [VALUE_W-1:0] anim_high;
		logic        [PITCH_W-1:0] anim_increment;
	} anim_cfg_t;

	typedef struct packed {
		logic [COLUMN_BITS-1:0]    column;
		logic [ROW_BITS-1:0]       row;
		logic signed [Z_W-1:0]     re;
		logic signed [Z_W-1:0]     im;
		logic signed [VALUE_W-1:0] c;
		logic                      done;
		logic [COUNT_W-1:0]        count;
		logic [SLOT_W-1:0]         slot;
	} jetp_item_t;

endpackage

FILE: sv/julia_escape_time_pixels.sv
// Top level of the Julia-set escape-time pixel engine.
// Holds the configuration registers, the chain of iteration cells and the result register.
// Depends on jetp_pkg, jetp_anim, jetp_map and jetp_cell.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+---------------------------
//   pixel    | pixel_valid / pixel_stall  | column, row, end_of_frame
//   result   | result_valid / result_stall| column, row, count, slot
//   config   | cfg_write                  | cfg_index, cfg_data
//
// One pixel is taken every cycle while pixel_stall is low; a pixel passes one mapping
// stage, two stages per iteration cell (three multipliers, then escape test and update)
// and the result register. Reset clears all valid bits and loads the configuration and
// the animated constant with their reset values. A stall on the result side fills empty
// stages first and then holds the pixel side.
module julia_escape_time_pixels #(
	parameter int MAX_ITERATIONS = jetp_pkg::MAX_ITERATIONS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              pixel_valid,
	output logic                              pixel_stall,
	input  jetp_pkg::pixel_req_t              pixel,
	output logic                              result_valid,
	input  logic                              result_stall,
	output jetp_pkg::pixel_res_t              result,
	input  logic                              cfg_write,
	input  logic [jetp_pkg::INDEX_W-1:0]      cfg_index,
	input  logic [jetp_pkg::VALUE_W-1:0]      cfg_data
);
	import jetp_pkg::*;

	localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(MAX_ITERATIONS);
	localparam logic [SLOT_W-1:0]  FULL_SLOT  = SLOT_W'(PALETTE_LENGTH % MAX_ITERATIONS);

	view_cfg_t                 view_q;
	anim_cfg_t                 anim_q;
	logic signed [VALUE_W-1:0] anim_value;
	logic                      frame_step;
	logic                      valid_c [0:MAX_ITERATIONS];
	logic                      stall_c [0:MAX_ITERATIONS];
	jetp_item_t                item_c  [0:MAX_ITERATIONS];
	jetp_item_t                last_item;
	logic                      result_valid_q;
	pixel_res_t                result_q;
	logic                      load_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			view_q.view_left    <= VIEW_LEFT_RESET;
			view_q.view_top     <= VIEW_TOP_RESET;
			view_q.pitch_x      <= PITCH_X_RESET;
			view_q.pitch_y      <= PITCH_Y_RESET;
			anim_q.anim_low       <= ANIM_LOW_RESET;
			anim_q.anim_high      <= ANIM_HIGH_RESET;
			anim_q.anim_increment <= ANIM_INCREMENT_RESET;
		end else if (cfg_write) begin
			case (cfg_reg_t'(cfg_index))
				REG_VIEW_LEFT: begin
					view_q.view_left <= cfg_data;
				end
				REG_VIEW_TOP: begin
					view_q.view_top <= cfg_data;
				end
				REG_PITCH_X: begin
					view_q.pitch_x <= cfg_data[PITCH_W-1:0];
				end
				REG_PITCH_Y: begin
					view_q.pitch_y <= cfg_data[PITCH_W-1:0];
				end
				REG_ANIM_LOW: begin
					anim_q.anim_low <= cfg_data;
				end
				REG_ANIM_HIGH: begin
					anim_q.anim_high <= cfg_data;
				end
				REG_ANIM_INCREMENT: begin
					anim_q.anim_increment <= cfg_data[PITCH_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign frame_step = pixel_valid && !pixel_stall && pixel.end_of_frame;

	jetp_anim u_anim (
		.clk        (clk),
		.arst_n     (arst_n),
		.frame_step (frame_step),
		.cfg        (anim_q),
		.value      (anim_value)
	);

	jetp_map u_map (
		.clk        (clk),
		.arst_n     (arst_n),
		.view       (view_q),
		.anim_value (anim_value),
		.valid_up   (pixel_valid),
		.pixel      (pixel),
		.stall_up   (pixel_stall),
		.valid_dn   (valid_c[0]),
		.item_dn    (item_c[0]),
		.stall_dn   (stall_c[0])
	);

	for (genvar i = 0; i < MAX_ITERATIONS; i++) begin : g_cell
		jetp_cell #(
			.INDEX (i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.valid_up (valid_c[i]),
			.item_up  (item_c[i]),
			.stall_up (stall_c[i]),
			.valid_dn (valid_c[i+1]),
			.item_dn  (item_c[i+1]),
			.stall_dn (stall_c[i+1])
		);
	end

	assign last_item = item_c[MAX_ITERATIONS];
	assign load_out  = !result_valid_q || !result_stall;
	assign stall_c[MAX_ITERATIONS] = !load_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (load_out) begin
			result_valid_q <= valid_c[MAX_ITERATIONS];
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			result_q.pixel_column <= last_item.column;
			result_q.pixel_row    <= last_item.row;
			result_q.escape_count <= last_item.done ? last_item.count : FULL_COUNT;
			result_q.colour_slot  <= last_item.done ? last_item.slot : FULL_SLOT;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	count_never_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid_q && (MAX_ITERATIONS < 8)) |-> (result_q.escape_count != '0))
		else $error("A result left with an escape count of zero.");

endmodule

FILE: sv/jetp_anim.sv
// Animated constant of the Julia iteration, stepped once per frame.
// Ping-pongs between the low and high turning points with saturation.
// Depends on jetp_pkg.
module jetp_anim (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               frame_step,
	input  jetp_pkg::anim_cfg_t                cfg,
	output logic signed [jetp_pkg::VALUE_W-1:0] value
);
	import jetp_pkg::*;

	localparam int SUM_W = VALUE_W + 2;
	localparam logic signed [SUM_W-1:0] VALUE_MAX = SUM_W'((1 << (VALUE_W - 1)) - 1);
	localparam logic signed [SUM_W-1:0] VALUE_MIN = SUM_W'(-(1 << (VALUE_W - 1)));

	logic signed [VALUE_W-1:0] value_q;
	logic                      rising_q;
	logic                      rising_next;
	logic signed [VALUE_W-1:0] low_v;
	logic signed [VALUE_W-1:0] high_v;
	logic signed [SUM_W-1:0]   base;
	logic signed [SUM_W-1:0]   inc_ext;
	logic signed [SUM_W-1:0]   sum;
	logic signed [VALUE_W-1:0] value_next;

	assign low_v   = cfg.anim_low;
	assign high_v  = cfg.anim_high;
	assign base    = SUM_W'(value_q);
	assign inc_ext = SUM_W'(cfg.anim_increment);

	always_comb begin
		rising_next = rising_q;
		if (value_q >= high_v) begin
			rising_next = 1'b0;
		end
		if (value_q <= low_v) begin
			rising_next = 1'b1;
		end
		sum = rising_next ? (base + inc_ext) : (base - inc_ext);
		if (sum > VALUE_MAX) begin
			value_next = VALUE_W'(VALUE_MAX);
		end else if (sum < VALUE_MIN) begin
			value_next = VALUE_W'(VALUE_MIN);
		end else begin
			value_next = VALUE_W'(sum);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_q  <= ANIM_VALUE_RESET;
			rising_q <= 1'b0;
		end else if (frame_step) begin
			value_q  <= value_next;
			rising_q <= rising_next;
		end
	end

	assign value = value_q;

	hold_between_frames: assert property (@(posedge clk) disable iff (!arst_n)
		!frame_step |=> $stable(value_q))
		else $error("Animated constant changed without a frame step.");

	turn_at_low: assert property (@(posedge clk) disable iff (!arst_n)
		(frame_step && (value_q <= low_v)) |=> rising_q)
		else $error("Animated constant did not turn upward at the low point.");

endmodule

FILE: sv/jetp_map.sv
// Maps a pixel's column and row to its start point in the complex plane.
// Latches the animated constant with the pixel and feeds the cell chain.
// Depends on jetp_pkg.
module jetp_map (
	input  logic                               clk,
	input  logic                               arst_n,
	input  jetp_pkg::view_cfg_t                view,
	input  logic signed [jetp_pkg::VALUE_W-1:0] anim_value,
	input  logic                               valid_up,
	input  jetp_pkg::pixel_req_t               pixel,
	output logic                               stall_up,
	output logic                               valid_dn,
	output jetp_pkg::jetp_item_t               item_dn,
	input  logic                               stall_dn
);
	import jetp_pkg::*;

	localparam int COL_PROD_W = COLUMN_BITS + PITCH_W;
	localparam int ROW_PROD_W = ROW_BITS + PITCH_W;

	logic                     valid_s1;
	jetp_item_t               item_s1;
	logic                     load_s1;
	logic [COL_PROD_W-1:0]    col_prod;
	logic [ROW_PROD_W-1:0]    row_prod;
	logic signed [Z_W-1:0]    re_start;
	logic signed [Z_W-1:0]    im_start;

	assign load_s1  = !valid_s1 || !stall_dn;
	assign stall_up = !load_s1;

	assign col_prod = COL_PROD_W'(pixel.column) * COL_PROD_W'(view.pitch_x);
	assign row_prod = ROW_PROD_W'(pixel.row) * ROW_PROD_W'(view.pitch_y);
	assign re_start = Z_W'(view.view_left) + Z_W'(view.pitch_x >> 1) + Z_W'(col_prod);
	assign im_start = Z_W'(view.view_top) + Z_W'(view.pitch_y >> 1) + Z_W'(row_prod);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= valid_up;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			item_s1.column <= pixel.column;
			item_s1.row    <= pixel.row;
			item_s1.re     <= re_start;
			item_s1.im     <= im_start;
			item_s1.c      <= anim_value;
			item_s1.done   <= 1'b0;
			item_s1.count  <= '0;
			item_s1.slot   <= '0;
		end
	end

	assign valid_dn = valid_s1;
	assign item_dn  = item_s1;

endmodule

FILE: sv/jetp_cell.sv
// One iteration cell: squares z, tests for escape and forms z*z + c.
// Two stages: products, then escape test and update; passes items on.
// Depends on jetp_pkg.
module jetp_cell #(
	parameter int INDEX = 0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 valid_up,
	input  jetp_pkg::jetp_item_t item_up,
	output logic                 stall_up,
	output logic                 valid_dn,
	output jetp_pkg::jetp_item_t item_dn,
	input  logic                 stall_dn
);
	import jetp_pkg::*;

	localparam int STEP_COUNT = (INDEX == 0) ? 1 : INDEX;
	localparam logic [COUNT_W-1:0] EXIT_COUNT = COUNT_W'(STEP_COUNT);
	localparam logic [SLOT_W-1:0]  EXIT_SLOT  = SLOT_W'(PALETTE_LENGTH % STEP_COUNT);
	localparam logic signed [PROD_W:0] LIMIT = (PROD_W + 1)'(4) <<< (2 * FRACTION_BITS);

	logic                       valid_s1;
	logic                       valid_s2;
	jetp_item_t                 item_s1;
	jetp_item_t                 item_s2;
	logic signed [PROD_W-1:0]   sq_re_s1;
	logic signed [PROD_W-1:0]   sq_im_s1;
	logic signed [PROD_W-1:0]   cross_s1;
	logic                       load_s1;
	logic                       load_s2;
	logic signed [Z_W-1:0]      re_up;
	logic signed [Z_W-1:0]      im_up;
	logic signed [VALUE_W-1:0]  c_s1;
	logic signed [PROD_W:0]     mag;
	logic signed [PROD_W:0]     diff;
	logic signed [PROD_W-1:0]   cross_shift;
	logic signed [PROD_W:0]     diff_shift;
	logic                       escape;
	jetp_item_t                 item_next;

	assign load_s2  = !valid_s2 || !stall_dn;
	assign load_s1  = !valid_s1 || load_s2;
	assign stall_up = !load_s1;

	assign re_up = item_up.re;
	assign im_up = item_up.im;
	assign c_s1  = item_s1.c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (load_s1) begin
				valid_s1 <= valid_up;
			end
			if (load_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			item_s1  <= item_up;
			sq_re_s1 <= re_up * re_up;
			sq_im_s1 <= im_up * im_up;
			cross_s1 <= re_up * im_up;
		end
	end

	assign mag         = (PROD_W + 1)'(sq_re_s1) + (PROD_W + 1)'(sq_im_s1);
	assign diff        = (PROD_W + 1)'(sq_re_s1) - (PROD_W + 1)'(sq_im_s1);
	assign diff_shift  = diff >>> FRACTION_BITS;
	assign cross_shift = cross_s1 >>> (FRACTION_BITS - 1);
	assign escape      = mag >= LIMIT;

	always_comb begin
		item_next = item_s1;
		if (!item_s1.done) begin
			if (escape) begin
				item_next.done  = 1'b1;
				item_next.count = EXIT_COUNT;
				item_next.slot  = EXIT_SLOT;
			end else begin
				item_next.re = Z_W'(diff_shift) + Z_W'(c_s1);
				item_next.im = Z_W'(cross_shift) + Z_W'(c_s1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			item_s2 <= item_next;
		end
	end

	assign valid_dn = valid_s2;
	assign item_dn  = item_s2;

	finished_item_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(load_s2 && valid_s1 && item_s1.done) |=> (item_s2 == $past(item_s1)))
		else $error("An escaped item was altered by a later cell.");

endmodule

FILE: bench/tb.sv
// Self-checking bench for julia_escape_time_pixels: directed rows, then random pixels.
// A local escape-time predictor over the configuration registers checks each result.
// Depends on jetp_pkg and julia_escape_time_pixels.
`timescale 1ns / 1ps

module tb;
	import jetp_pkg::*;

	localparam int CLK_HALF        = 5;
	localparam int LATENCY         = 2 * MAX_ITERATIONS + 2;
	localparam int SETTLE_CYCLES   = LATENCY + 4;
	localparam int RANDOM_PHASES   = 8;
	localparam int ITEMS_PER_PHASE = 250;
	localparam int HOLD_CYCLES     = 200;
	localparam int WATCHDOG_LIMIT  = 5000;

	typedef enum bit {STEP_PIXEL, STEP_WRITE} step_kind_t;

	typedef struct {
		step_kind_t           kind;
		cfg_reg_t             reg_id;
		logic [VALUE_W-1:0]   data;
		pixel_req_t           px;
		bit                   typed;
		logic [COUNT_W-1:0]   count;
		logic [SLOT_W-1:0]    slot;
	} directed_step_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 pixel_valid;
	logic                 pixel_stall;
	pixel_req_t           pixel;
	logic                 result_valid;
	logic                 result_stall;
	pixel_res_t           result;
	logic                 cfg_write;
	logic [INDEX_W-1:0]   cfg_index;
	logic [VALUE_W-1:0]   cfg_data;

	view_cfg_t                  view_model;
	anim_cfg_t                  anim_model;
	logic signed [VALUE_W-1:0]  anim_value;
	bit                         anim_rising;

	pixel_res_t       pending_results[$];
	directed_step_t   directed[$];
	int               mismatches;
	int               pixels_sent;
	int               results_seen;
	int               reg_writes;
	int               escape_seen[8];
	int               idle_cycles;
	bit               hold_request;
	bit               long_hold;

	julia_escape_time_pixels uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.pixel_valid  (pixel_valid),
		.pixel_stall  (pixel_stall),
		.pixel        (pixel),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #(CLK_HALF) clk = ~clk;

	// Escape-time result of one pixel; an end-of-frame pixel then moves the animated constant.
	function automatic pixel_res_t julia_predict(pixel_req_t p);
		longint re, im, nr, ni, c, radius_sq, v;
		int unsigned steps;
		pixel_res_t r;
		re = longint'(view_model.view_left) + longint'(view_model.pitch_x >> 1)
			+ longint'(p.column) * longint'(view_model.pitch_x);
		im = longint'(view_model.view_top) + longint'(view_model.pitch_y >> 1)
			+ longint'(p.row) * longint'(view_model.pitch_y);
		c = longint'(anim_value);
		radius_sq = longint'(4) << (2 * FRACTION_BITS);
		steps = 0;
		while (steps < MAX_ITERATIONS) begin
			if (re * re + im * im >= radius_sq)
				break;
			nr = ((re * re - im * im) >>> FRACTION_BITS) + c;
			ni = ((2 * re * im) >>> FRACTION_BITS) + c;
			re = nr;
			im = ni;
			steps++;
		end
		if (steps == 0)
			steps = 1;
		r.pixel_column = p.column;
		r.pixel_row = p.row;
		r.escape_count = steps[COUNT_W-1:0];
		r.colour_slot = SLOT_W'(PALETTE_LENGTH % steps);
		if (p.end_of_frame) begin
			if (anim_value >= anim_model.anim_high)
				anim_rising = 1'b0;
			if (anim_value <= anim_model.anim_low)
				anim_rising = 1'b1;
			v = anim_rising ? longint'(anim_value) + longint'(anim_model.anim_increment)
				: longint'(anim_value) - longint'(anim_model.anim_increment);
			if (v > 32767)
				v = 32767;
			if (v < -32768)
				v = -32768;
			anim_value = v[VALUE_W-1:0];
		end
		return r;
	endfunction

	function automatic void add_row(step_kind_t kind, cfg_reg_t id, int data, int col, int rw,
			int eof, int typed, int count, int slot);
		directed_step_t s;
		s.kind = kind;
		s.reg_id = id;
		s.data = VALUE_W'(data);
		s.px.column = COLUMN_BITS'(col);
		s.px.row = ROW_BITS'(rw);
		s.px.end_of_frame = 1'(eof);
		s.typed = 1'(typed);
		s.count = COUNT_W'(count);
		s.slot = SLOT_W'(slot);
		directed.insert(directed.size(), s);
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [VALUE_W-1:0] pick_setting(cfg_reg_t id);
		int lo, hi;
		int unsigned sel;
		bit is_signed;
		is_signed = 1'b1;
		case (id)
			REG_VIEW_LEFT, REG_VIEW_TOP: begin
				lo = -12288;
				hi = 4096;
			end
			REG_PITCH_X: begin
				lo = 0;
				hi = 160;
				is_signed = 1'b0;
			end
			REG_PITCH_Y: begin
				lo = 0;
				hi = 320;
				is_signed = 1'b0;
			end
			REG_ANIM_LOW: begin
				lo = -4096;
				hi = 2048;
			end
			REG_ANIM_HIGH: begin
				lo = 0;
				hi = 6144;
			end
			default: begin
				lo = 0;
				hi = 600;
				is_signed = 1'b0;
			end
		endcase
		sel = $urandom_range(0, 9);
		if (sel == 0)
			return is_signed ? 16'h8000 : 16'h0000;
		if (sel == 1)
			return 16'h7FFF;
		if (sel == 2)
			return VALUE_W'($urandom_range(0, 16'hFFFF));
		return VALUE_W'(int'($urandom_range(0, hi - lo)) + lo);
	endfunction

	// Drops valid and waits until every expected result has arrived and the pipeline is empty.
	task automatic settle();
		@(negedge clk);
		pixel_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t id, logic [VALUE_W-1:0] data);
		settle();
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= id;
		cfg_data <= data;
		@(negedge clk);
		cfg_write <= 1'b0;
		case (id)
			REG_VIEW_LEFT:      view_model.view_left = data;
			REG_VIEW_TOP:       view_model.view_top = data;
			REG_PITCH_X:        view_model.pitch_x = data[PITCH_W-1:0];
			REG_PITCH_Y:        view_model.pitch_y = data[PITCH_W-1:0];
			REG_ANIM_LOW:       anim_model.anim_low = data;
			REG_ANIM_HIGH:      anim_model.anim_high = data;
			REG_ANIM_INCREMENT: anim_model.anim_increment = data[PITCH_W-1:0];
			default: ;
		endcase
		reg_writes++;
	endtask

	task automatic send_pixel(pixel_req_t p, bit typed, logic [COUNT_W-1:0] count,
			logic [SLOT_W-1:0] slot, bit steady);
		int unsigned gap;
		pixel_res_t want;
		gap = (steady || long_hold) ? 0 : pick_gap();
		if (gap != 0) begin
			@(negedge clk);
			pixel_valid <= 1'b0;
			pixel <= pixel_req_t'(16'($urandom_range(0, 16'hFFFF)));
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		pixel_valid <= 1'b1;
		pixel <= p;
		do @(posedge clk); while (pixel_stall);
		want = julia_predict(p);
		if (typed) begin
			want.escape_count = count;
			want.colour_slot = slot;
		end
		pending_results.insert(pending_results.size(), want);
		pixels_sent++;
	endtask

	initial begin : stimulus
		pixel_req_t p;
		logic [VALUE_W-1:0] v;
		arst_n = 1'b0;
		pixel_valid = 1'b0;
		pixel = '0;
		result_stall = 1'b0;
		cfg_write = 1'b0;
		cfg_index = REG_VIEW_LEFT;
		cfg_data = '0;
		hold_request = 1'b0;
		long_hold = 1'b0;
		view_model.view_left = VIEW_LEFT_RESET;
		view_model.view_top = VIEW_TOP_RESET;
		view_model.pitch_x = PITCH_X_RESET;
		view_model.pitch_y = PITCH_Y_RESET;
		anim_model.anim_low = ANIM_LOW_RESET;
		anim_model.anim_high = ANIM_HIGH_RESET;
		anim_model.anim_increment = ANIM_INCREMENT_RESET;
		anim_value = ANIM_VALUE_RESET;
		anim_rising = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		//      kind        register            data    col  row eof typed cnt slot
		add_row(STEP_PIXEL, REG_VIEW_LEFT,      0,      0,   0,  0,  0,    0,  0);
		add_row(STEP_PIXEL, REG_VIEW_LEFT,      0,      255, 127, 0, 0,    0,  0);
		add_row(STEP_PIXEL, REG_VIEW_LEFT,      0,      128, 64, 0,  0,    0,  0);
		add_row(STEP_PIXEL, REG_VIEW_LEFT,      0,      37,  90, 1,  0,    0,  0);
		add_row(STEP_PIXEL, REG_VIEW_LEFT,      0,      200, 5,  1,  0,    0,  0);
		// Far outside the escape radius: no step is taken and the count reads as one.
		add_row(STEP_WRITE, REG_VIEW_LEFT,      32767,  0,   0,  0,  0,    0,  0);
		add_row(STEP_WRITE, REG_VIEW_TOP,       32767,  0,   0,  0,  0,    0,  0);
		add_row(STEP_PIXEL, REG_VIEW_LEFT,      0,      0,   0,  0,  1,    1,  0);
		add_row(STEP_PIXEL, REG_VIEW_LEFT,      0,      255, 127, 1, 1,    1,  0);
		add_row(STEP_WRITE, REG_VIEW_LEFT,      -32768, 0,   0,  0,  0,    0,  0);
		add_row(STEP_WRITE, REG_VIEW_TOP,       -32768, 0,   0,  0,  0,    0,  0);
		add_row(STEP_WRITE, REG_PITCH_X,        0,      0,   0,  0,  0,    0,  0);
		add_row(STEP_WRITE, REG_PITCH_Y,        0,      0,   0,  0,  0,    0,  0);
		add_row(STEP_PIXEL, REG_VIEW_LEFT,      0,      0,   0,  0,  1,    1,  0);
		add_row(STEP_PIXEL, REG_VIEW_LEFT,      0,      255, 127, 0, 1,    1,  0);
		// Orbit from the origin while the animated constant turns and saturates.
		add_row(STEP_WRITE, REG_VIEW_LEFT,      0,      0,   0,  0,  0,    0,  0);
		add_row(STEP_WRITE, REG_VIEW_TOP,       0,      0,   0,  0,  0,    0,  0);
		add_row(STEP_WRITE, REG_ANIM_LOW,       32767,  0,   0,  0,  0,    0,  0);
		add_row(STEP_WRITE, REG_ANIM_HIGH,      -32768, 0,   0,  0,  0,    0,  0);
		add_row(STEP_WRITE, REG_ANIM_INCREMENT, 32767,  0,   0,  0,  0,    0,  0);
		add_row(STEP_PIXEL, REG_VIEW_LEFT,      0,      0,   0,  1,  0,    0,  0);
		add_row(STEP_PIXEL, REG_VIEW_LEFT,      0,      1,   1,  1,  0,    0,  0);
		add_row(STEP_PIXEL, REG_VIEW_LEFT,      0,      2,   2,  0,  0,    0,  0);
		add_row(STEP_WRITE, REG_ANIM_LOW,       -32768, 0,   0,  0,  0,    0,  0);
		add_row(STEP_WRITE, REG_ANIM_HIGH,      32767,  0,   0,  0,  0,    0,  0);
		add_row(STEP_PIXEL, REG_VIEW_LEFT,      0,      3,   3,  1,  0,    0,  0);
		add_row(STEP_PIXEL, REG_VIEW_LEFT,      0,      4,   4,  1,  0,    0,  0);
		add_row(STEP_PIXEL, REG_VIEW_LEFT,      0,      5,   5,  1,  0,    0,  0);
		add_row(STEP_PIXEL, REG_VIEW_LEFT,      0,      6,   6,  1,  0,    0,  0);
		add_row(STEP_PIXEL, REG_VIEW_LEFT,      0,      7,   7,  0,  0,    0,  0);

		foreach (directed[k]) begin
			if (directed[k].kind == STEP_WRITE)
				write_reg(directed[k].reg_id, directed[k].data);
			else
				send_pixel(directed[k].px, directed[k].typed, directed[k].count,
					directed[k].slot, 1'b0);
		end

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			for (int i = 0; i <= int'(REG_ANIM_INCREMENT); i++) begin
				if (ph == 0)
					v = 16'h7FFF;
				else if (ph == 1)
					v = (cfg_reg_t'(i) inside {REG_PITCH_X, REG_PITCH_Y, REG_ANIM_INCREMENT})
						? 16'h0000 : 16'h8000;
				else
					v = pick_setting(cfg_reg_t'(i));
				write_reg(cfg_reg_t'(i), v);
			end
			if (ph == 3)
				hold_request = 1'b1;
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				p.column = COLUMN_BITS'($urandom_range(0, 255));
				p.row = ROW_BITS'($urandom_range(0, 127));
				p.end_of_frame = ($urandom_range(0, 15) == 0);
				send_pixel(p, 1'b0, '0, '0, (ph % 3) == 1);
			end
		end

		settle();
		$display("Checked %0d results from %0d pixels with %0d register writes and one long result hold.",
			results_seen, pixels_sent, reg_writes);
		$display("Escape counts seen: 1:%0d 2:%0d 3:%0d 4:%0d.",
			escape_seen[1], escape_seen[2], escape_seen[3], escape_seen[4]);
		if (mismatches == 0)
			$display("PASS julia_escape_time_pixels");
		else
			$display("FAIL julia_escape_time_pixels");
		$finish;
	end

	initial begin : receiver
		int unsigned r, free_len, stall_len;
		@(posedge arst_n);
		forever begin
			r = $urandom_range(0, 99);
			free_len = (r < 60) ? $urandom_range(1, 3)
				: (r < 90) ? $urandom_range(4, 12) : $urandom_range(30, 120);
			@(negedge clk);
			result_stall <= 1'b0;
			repeat (free_len - 1) @(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				long_hold = 1'b1;
				stall_len = HOLD_CYCLES;
			end else begin
				r = $urandom_range(0, 99);
				stall_len = (r < 70) ? $urandom_range(1, 2)
					: (r < 95) ? $urandom_range(3, 8) : $urandom_range(20, 60);
			end
			@(negedge clk);
			result_stall <= 1'b1;
			repeat (stall_len - 1) @(negedge clk);
			long_hold = 1'b0;
		end
	end

	always @(posedge clk) begin : result_check
		pixel_res_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_results.size() == 0) begin
				$error("Result transfer with no pixel outstanding: column %0d, row %0d.",
					result.pixel_column, result.pixel_row);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				if (result.pixel_column !== want.pixel_column) begin
					$error("pixel_column: expected %0d, got %0d", want.pixel_column,
						result.pixel_column);
					mismatches++;
				end
				if (result.pixel_row !== want.pixel_row) begin
					$error("pixel_row: expected %0d, got %0d", want.pixel_row, result.pixel_row);
					mismatches++;
				end
				if (result.escape_count !== want.escape_count) begin
					$error("escape_count: expected %0d, got %0d", want.escape_count,
						result.escape_count);
					mismatches++;
				end
				if (result.colour_slot !== want.colour_slot) begin
					$error("colour_slot: expected %0d, got %0d", want.colour_slot,
						result.colour_slot);
					mismatches++;
				end
				escape_seen[want.escape_count]++;
				results_seen++;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (pixel_valid && !pixel_stall) || (result_valid && !result_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Timed out with %0d results outstanding.", pending_results.size());
			$display("FAIL julia_escape_time_pixels");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule
